### rtl/early_exit_histogram_scan_macros.svh
// Assertion macros for the early-exit histogram scan.
// Used by early_exit_histogram_scan.sv; each macro expects clk and rst_n in scope.
`ifndef EARLY_EXIT_HISTOGRAM_SCAN_MACROS_SVH
`define EARLY_EXIT_HISTOGRAM_SCAN_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define EEHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define EEHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define EEHS_ASSERT_IMP(lbl, ante, cons)
`define EEHS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### rtl/eehs_pkg.sv
// Shared constants and types for the early-exit histogram scan.
// No dependencies; used by early_exit_histogram_scan.sv.
package eehs_pkg;

  localparam int NUM_CONF   = 7;
  localparam int CONF_W     = 16;
  localparam int CONF_USE_W = 15;
  localparam int IN_TDATA_W = NUM_CONF * CONF_W;

  localparam int THR_W    = 15;
  localparam int FIELDS_W = 3;
  localparam int CFG_W    = 15;

  localparam logic [THR_W-1:0]    THRESH_RESET = 15'd18022;
  localparam logic [FIELDS_W-1:0] FIELDS_RESET = 3'd4;

  localparam int OUT_BIN_W   = 3;
  localparam int OUT_CNT_W   = 40;
  localparam int OUT_USED_W  = OUT_BIN_W + 2 * OUT_CNT_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  typedef enum logic [0:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_FIELDS    = 1'b1
  } cfg_idx_t;

endpackage

### rtl/early_exit_histogram_scan.sv
// Early-exit histogram scan: exit-index histogram kept in a synchronous memory.
// Depends on eehs_pkg and early_exit_histogram_scan_macros.svh.
//
// Samples: one transfer per cycle outside a report sweep; the bin is read at the transfer
// edge, then incremented and written back at the next edge, with a one-entry forward path
// for repeats. Reports: MAX_EXITS results via the read stage and output register, one per
// cycle while out_tready is high; in_tready stays low until the last read leaves the read
// stage, as the sweep shares the single memory read port. Reset: registers return
// to their reset values and per-bin valid bits clear at once, so no clearing pass is needed.
`include "early_exit_histogram_scan_macros.svh"

module early_exit_histogram_scan #(
  parameter int MAX_EXITS  = 8,
  parameter int COUNT_BITS = 40
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [0:0]                           cfg_addr,
  input  logic [eehs_pkg::CFG_W-1:0]           cfg_wdata,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [eehs_pkg::IN_TDATA_W-1:0]      in_tdata,  // conf_0 .. conf_6, 16 bits each
  input  logic                                 in_tuser,  // mode
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [eehs_pkg::OUT_TDATA_W-1:0]     out_tdata, // bin, bin_count, catastrophes, pad
  output logic                                 out_tlast
);

  localparam int EXIT_W = (MAX_EXITS > 1) ? $clog2(MAX_EXITS) : 1;
  localparam int CNT_W  = $clog2(MAX_EXITS + 1);
  localparam int NLIM   = (MAX_EXITS - 1 < eehs_pkg::NUM_CONF) ? MAX_EXITS - 1
                                                               : eehs_pkg::NUM_CONF;
  localparam int CW     = (COUNT_BITS > eehs_pkg::OUT_CNT_W) ? COUNT_BITS
                                                             : eehs_pkg::OUT_CNT_W;
  localparam int BW     = (EXIT_W > eehs_pkg::OUT_BIN_W) ? EXIT_W : eehs_pkg::OUT_BIN_W;
  localparam logic [eehs_pkg::OUT_BIN_W-1:0] LAST_BIN =
    eehs_pkg::OUT_BIN_W'((MAX_EXITS - 1) % 8);

  // configuration registers
  logic [eehs_pkg::THR_W-1:0]    thr_r;
  logic [eehs_pkg::FIELDS_W-1:0] fields_r;

  // histogram memory with per-bin valid bits
  logic [COUNT_BITS-1:0] mem [MAX_EXITS];
  logic [MAX_EXITS-1:0]  vld_r;
  logic [COUNT_BITS-1:0] mem_q_r;
  logic                  rd_hit_r;
  logic                  rd_en;
  logic [EXIT_W-1:0]     rd_addr;

  // sample pipeline
  logic                  s1_vld_r;
  logic [EXIT_W-1:0]     s1_idx_r;
  logic [COUNT_BITS-1:0] s1_base;
  logic [COUNT_BITS-1:0] s1_new;
  logic                  fwd_vld_r;
  logic [EXIT_W-1:0]     fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic [COUNT_BITS-1:0] cat_r;
  logic [COUNT_BITS-1:0] cat_snap_r;

  // report sweep
  logic                  rpt_busy_r;
  logic [CNT_W-1:0]      rpt_idx_r;
  logic                  rpt_issue;
  logic                  rpt_done;
  logic                  rdv_r;
  logic [EXIT_W-1:0]     rd_bin_r;
  logic                  rd_last_r;

  // output register
  logic                              out_tvalid_r;
  logic [eehs_pkg::OUT_BIN_W-1:0]    out_bin_r;
  logic [eehs_pkg::OUT_CNT_W-1:0]    out_cnt_r;
  logic [eehs_pkg::OUT_CNT_W-1:0]    out_cat_r;
  logic                              out_last_r;
  logic                              out_load;

  logic                              in_xfer;
  logic                              samp_xfer;
  logic                              rpt_xfer;
  logic [eehs_pkg::FIELDS_W-1:0]     n_use;
  logic [EXIT_W-1:0]                 samp_idx;
  logic                              samp_cat;
  logic [COUNT_BITS-1:0]             rd_cnt;
  logic [CW-1:0]                     cnt_wide;
  logic [CW-1:0]                     cat_wide;
  logic [BW-1:0]                     bin_wide;

  assign in_tready = !rpt_busy_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign samp_xfer = in_xfer && !in_tuser;
  assign rpt_xfer  = in_xfer && in_tuser;

  // exit index: first checked field at or above threshold; if none, n_use and a catastrophe
  always_comb begin
    n_use = (fields_r > eehs_pkg::FIELDS_W'(NLIM)) ? eehs_pkg::FIELDS_W'(NLIM) : fields_r;
    samp_idx = EXIT_W'(n_use);
    samp_cat = 1'b1;
    for (int k = eehs_pkg::NUM_CONF - 1; k >= 0; k--) begin
      if ((eehs_pkg::FIELDS_W'(k) < n_use) &&
          (in_tdata[k*eehs_pkg::CONF_W +: eehs_pkg::CONF_USE_W] >= thr_r)) begin
        samp_idx = EXIT_W'(k);
        samp_cat = 1'b0;
      end
    end
  end

  assign out_load  = rdv_r && (!out_tvalid_r || out_tready);
  assign rpt_issue = rpt_busy_r && (rpt_idx_r != CNT_W'(MAX_EXITS)) && (!rdv_r || out_load);
  assign rpt_done  = rpt_busy_r && (rpt_idx_r == CNT_W'(MAX_EXITS)) && (!rdv_r || out_load);

  assign rd_en   = rpt_issue || samp_xfer;
  assign rd_addr = rpt_issue ? rpt_idx_r[EXIT_W-1:0] : samp_idx;
  assign rd_cnt  = rd_hit_r ? mem_q_r : '0;

  // take the write from last cycle over the stale memory read
  assign s1_base = (fwd_vld_r && (fwd_addr_r == s1_idx_r)) ? fwd_data_r : rd_cnt;
  assign s1_new  = (&s1_base) ? s1_base : s1_base + COUNT_BITS'(1);

  // memory port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
    if (s1_vld_r) begin
      mem[s1_idx_r] <= s1_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_hit_r <= vld_r[rd_addr];
      end
      if (s1_vld_r) begin
        vld_r[s1_idx_r] <= 1'b1;
      end else if (rpt_issue) begin
        // drop the bin once it has been read out
        vld_r[rpt_idx_r[EXIT_W-1:0]] <= 1'b0;
      end
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= eehs_pkg::THRESH_RESET;
      fields_r <= eehs_pkg::FIELDS_RESET;
    end else if (cfg_we) begin
      case (eehs_pkg::cfg_idx_t'(cfg_addr))
        eehs_pkg::CFG_THRESHOLD: thr_r    <= cfg_wdata[eehs_pkg::THR_W-1:0];
        eehs_pkg::CFG_FIELDS:    fields_r <= cfg_wdata[eehs_pkg::FIELDS_W-1:0];
        default: ;
      endcase
    end
  end

  // sample pipeline and catastrophe counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      cat_r     <= '0;
    end else begin
      s1_vld_r  <= samp_xfer;
      fwd_vld_r <= s1_vld_r;
      if (rpt_xfer) begin
        cat_r <= '0;
      end else if (samp_xfer && samp_cat && !(&cat_r)) begin
        cat_r <= cat_r + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (samp_xfer) begin
      s1_idx_r <= samp_idx;
    end
    if (s1_vld_r) begin
      fwd_addr_r <= s1_idx_r;
      fwd_data_r <= s1_new;
    end
    if (rpt_xfer) begin
      cat_snap_r <= cat_r;
    end
  end

  // report sweep and read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpt_busy_r <= 1'b0;
      rpt_idx_r  <= '0;
      rdv_r      <= 1'b0;
    end else begin
      if (rpt_xfer) begin
        rpt_busy_r <= 1'b1;
        rpt_idx_r  <= '0;
      end else begin
        if (rpt_done) begin
          rpt_busy_r <= 1'b0;
        end
        if (rpt_issue) begin
          rpt_idx_r <= rpt_idx_r + CNT_W'(1);
        end
      end
      if (rpt_issue) begin
        rdv_r <= 1'b1;
      end else if (out_load) begin
        rdv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rpt_issue) begin
      rd_bin_r  <= rpt_idx_r[EXIT_W-1:0];
      rd_last_r <= (rpt_idx_r == CNT_W'(MAX_EXITS - 1));
    end
  end

  // output register
  assign cnt_wide = CW'(rd_cnt);
  assign cat_wide = CW'(cat_snap_r);
  assign bin_wide = BW'(rd_bin_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_r  <= bin_wide[eehs_pkg::OUT_BIN_W-1:0];
      out_cnt_r  <= cnt_wide[eehs_pkg::OUT_CNT_W-1:0];
      out_cat_r  <= cat_wide[eehs_pkg::OUT_CNT_W-1:0];
      out_last_r <= rd_last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{eehs_pkg::OUT_PAD_W{1'b0}}, out_cat_r, out_cnt_r, out_bin_r};

  // checks
  `EEHS_ASSERT_IMP(a_rd_stage_held, rdv_r && !out_load, !rd_en)
  `EEHS_ASSERT_IMP(a_last_on_final_bin, out_tvalid_r && out_last_r, out_bin_r == LAST_BIN)
  `EEHS_ASSERT_NXT(a_report_clears, rpt_xfer, (cat_r == '0) && rpt_busy_r)
  `EEHS_ASSERT_IMP(a_no_write_in_sweep, rpt_issue, !s1_vld_r && !samp_xfer)

endmodule
